/* hw/rtl/cal_pkg.sv */
// shared types and constants for the cursor array list
`default_nettype none
package cal_pkg;
   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic [3:0] {
      OP_CLEAR   = 4'd0,  OP_INSERT  = 4'd1,  OP_APPEND  = 4'd2,  OP_REMOVE  = 4'd3,
      OP_START   = 4'd4,  OP_END     = 4'd5,  OP_PREV    = 4'd6,  OP_NEXT    = 4'd7,
      OP_SEEK    = 4'd8,  OP_READ    = 4'd9,  OP_REVERSE = 4'd10, OP_FINDMIN = 4'd11,
      OP_FINDMAX = 4'd12, OP_RMMIN   = 4'd13, OP_RMMAX   = 4'd14, OP_RMRANGE = 4'd15
   } op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] value;
      logic [4:0]         index;
      logic [4:0]         last_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
      logic [4:0]         position;
      logic [4:0]         cursor_now;
      logic [4:0]         size_now;
   } rsp_type;

   // datapath commands, one per cycle
   typedef enum logic [2:0] {
      DC_IDLE,    // nothing
      DC_LOAD,    // latch request, set pointers from it
      DC_RDA,     // issue the walk read (at a, a-1 or a+1, or at b for a range)
      DC_RDB,     // issue read at pointer b, capture a
      DC_WR,      // write step of the active walk
      DC_SCAN,    // extreme search step
      DC_FINISH   // update size and cursor, build result
   } dcmd_type;

   typedef struct packed {
      dcmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic walk_done;  // current walk has no more steps
      logic scan_done;  // search passed the last element
      logic err;        // request needs no datapath walk
   } sts_type;
endpackage
`default_nettype wire

/* hw/rtl/cal_datapath.sv */
// element memory, pointers and result building for the cursor array list
`default_nettype none
module cal_datapath
   import cal_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req,
   input  wire ctl_type ctl,
   output sts_type      sts,
   output rsp_type      rsp
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_ff;
   logic [DATA_WIDTH-1:0] hold_ff, best_ff, val_ff;
   logic [CW-1:0] size_ff, cur_ff, a_ff, b_ff, best_i_ff, lim_ff;
   logic [CW-1:0] size_in, cur_in, a_in, b_in, best_i_in, lim_in;
   logic [3:0]  mode_ff;
   logic [4:0]  m_ff;
   logic        err_ff, scan_phase_ff, scan_phase_in, first_ff, first_in;
   logic [1:0]  status_ff;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [4:0]  pos_ff;
   logic        ext_max;
   logic        better;
   logic        wr_en;
   logic [CW-1:0] wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [CW-1:0] rd_addr;
   logic        rd_en;
   logic [1:0]  err_status;
   logic        err_any;
   logic [CW:0] m_w, n_w, sz_w;

   assign ext_max = (mode_ff == OP_FINDMAX) || (mode_ff == OP_RMMAX);
   assign better = ext_max ? ($signed(best_ff) < $signed(rd_ff))
                           : ($signed(rd_ff) < $signed(best_ff));
   assign m_w  = (CW+1)'(req.index);
   assign n_w  = (CW+1)'(req.last_index);
   assign sz_w = {1'b0, size_ff};

   // error checks on the incoming request
   always_comb begin
      err_status = ST_OK;
      err_any = 1'b0;
      case (op_type'(req.mode))
         OP_INSERT, OP_APPEND: if (size_ff >= CW'(CAPACITY)) begin
            err_status = ST_FULL; err_any = 1'b1;
         end
         OP_REMOVE, OP_READ: if (cur_ff >= size_ff) begin
            err_status = ST_EMPTY; err_any = 1'b1;
         end
         OP_FINDMIN, OP_FINDMAX, OP_RMMIN, OP_RMMAX: if (size_ff == '0) begin
            err_status = ST_EMPTY; err_any = 1'b1;
         end
         OP_SEEK: if (m_w > sz_w) begin
            err_status = ST_RANGE; err_any = 1'b1;
         end
         OP_RMRANGE: if (m_w > n_w) err_any = 1'b1;
            else if (n_w >= sz_w) begin
               err_status = ST_RANGE; err_any = 1'b1;
            end
         OP_REVERSE: err_any = 1'b0;
         OP_CLEAR, OP_START, OP_END, OP_PREV, OP_NEXT: err_any = 1'b1;
         default: err_any = 1'b1;
      endcase
   end

   // walk control: a is the read/write pointer, b the partner, lim the stop
   always_comb begin
      a_in = a_ff; b_in = b_ff; lim_in = lim_ff; size_in = size_ff; cur_in = cur_ff;
      best_i_in = best_i_ff; scan_phase_in = scan_phase_ff; first_in = first_ff;
      data_in = data_ff;
      wr_en = 1'b0; wr_addr = a_ff; wr_data = hold_ff;
      rd_en = 1'b0; rd_addr = a_ff;
      sts.walk_done = 1'b0;
      sts.scan_done = 1'b0;
      sts.err = err_ff;
      case (ctl.cmd)
         DC_LOAD: begin
            first_in = 1'b1;
            scan_phase_in = 1'b0;
            best_i_in = '0;
            data_in = '0;
            case (op_type'(req.mode))
               OP_INSERT: begin a_in = size_ff; lim_in = cur_ff; end
               OP_APPEND: begin a_in = size_ff; lim_in = size_ff; end
               OP_REMOVE: begin a_in = cur_ff; lim_in = size_ff - 1'b1; end
               OP_READ:   begin a_in = cur_ff; lim_in = cur_ff; end
               OP_REVERSE: begin a_in = '0; b_in = size_ff - 1'b1; end
               OP_RMRANGE: begin
                  a_in = CW'(req.index);
                  b_in = CW'(req.last_index) + 1'b1;
                  lim_in = size_ff - (CW'(req.last_index) - CW'(req.index) + 1'b1);
               end
               default: begin a_in = '0; b_in = '0; lim_in = size_ff; end
            endcase
         end
         DC_RDA: begin
            // reads for the walk: insert moves a-1 up, removals move a+1 (or b for a range) down
            rd_en = 1'b1;
            case (op_type'(mode_ff))
               OP_INSERT: begin
                  rd_addr = a_ff - 1'b1;
                  sts.walk_done = (a_ff == lim_ff);
               end
               OP_APPEND: sts.walk_done = 1'b1;
               OP_REMOVE, OP_RMMIN, OP_RMMAX: begin
                  rd_addr = a_ff + 1'b1;
                  // the removed word is captured before the walk can end
                  sts.walk_done = !first_ff && (a_ff >= lim_ff);
                  if (first_ff) begin
                     rd_addr = a_ff;
                  end
               end
               OP_READ: rd_addr = a_ff;
               OP_REVERSE: begin
                  rd_addr = a_ff;
                  sts.walk_done = !(a_ff < b_ff) || (size_ff == '0);
               end
               OP_RMRANGE: begin
                  rd_addr = b_ff;
                  sts.walk_done = (a_ff >= lim_ff);
               end
               default: begin
                  rd_addr = a_ff;
                  sts.walk_done = 1'b1;
               end
            endcase
         end
         DC_RDB: begin
            rd_en = 1'b1;
            rd_addr = b_ff;
         end
         DC_WR: begin
            wr_en = 1'b1;
            case (op_type'(mode_ff))
               OP_INSERT: begin
                  sts.walk_done = (a_ff == lim_ff);
                  if (a_ff == lim_ff) wr_data = val_ff;
                  else begin wr_data = rd_ff; a_in = a_ff - 1'b1; end
               end
               OP_APPEND: begin wr_data = val_ff; sts.walk_done = 1'b1; end
               OP_REMOVE, OP_RMMIN, OP_RMMAX: begin
                  if (first_ff) begin
                     wr_en = 1'b0;
                     data_in = rd_ff;
                     first_in = 1'b0;
                  end else begin
                     wr_data = rd_ff;
                     a_in = a_ff + 1'b1;
                  end
               end
               OP_READ: begin wr_en = 1'b0; data_in = rd_ff; sts.walk_done = 1'b1; end
               OP_REVERSE: begin
                  // swap: first write b's word at a, then the held a word at b
                  if (first_ff) begin
                     wr_addr = a_ff; wr_data = rd_ff; first_in = 1'b0;
                  end else begin
                     wr_addr = b_ff; wr_data = hold_ff; first_in = 1'b1;
                     a_in = a_ff + 1'b1; b_in = b_ff - 1'b1;
                  end
               end
               OP_RMRANGE: begin
                  wr_data = rd_ff; a_in = a_ff + 1'b1; b_in = b_ff + 1'b1;
               end
               default: wr_en = 1'b0;
            endcase
         end
         DC_SCAN: begin
            // read b, compare the previous read against best
            rd_en = 1'b1;
            rd_addr = b_ff;
            if (scan_phase_ff) begin
               if (a_ff == '0 || better) best_i_in = a_ff;
               a_in = a_ff + 1'b1;
            end
            scan_phase_in = 1'b1;
            b_in = b_ff + 1'b1;
            sts.scan_done = scan_phase_ff && (a_ff + 1'b1 >= size_ff);
            if (sts.scan_done) begin
               a_in = (a_ff == '0 || better) ? a_ff : best_i_ff;
               lim_in = size_ff - 1'b1;
            end
         end
         DC_FINISH: begin
            case (op_type'(mode_ff))
               OP_CLEAR: begin size_in = '0; cur_in = '0; end
               OP_INSERT, OP_APPEND: if (!err_ff) size_in = size_ff + 1'b1;
               OP_REMOVE, OP_RMMIN, OP_RMMAX: if (!err_ff) size_in = size_ff - 1'b1;
               OP_START: cur_in = '0;
               OP_END: cur_in = (size_ff != '0) ? size_ff - 1'b1 : '0;
               OP_PREV: if (cur_ff != '0) cur_in = cur_ff - 1'b1;
               OP_NEXT: if (cur_ff < size_ff) cur_in = cur_ff + 1'b1;
               OP_SEEK: if (!err_ff) cur_in = CW'(m_ff);
               OP_REVERSE: cur_in = size_ff - cur_ff;
               OP_RMRANGE: if (!err_ff) size_in = lim_ff;
               default: ;
            endcase
            if (cur_in > size_in) cur_in = size_in;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         cur_ff  <= '0;
      end else begin
         size_ff <= size_in;
         cur_ff  <= cur_in;
      end
      a_ff <= a_in; b_ff <= b_in; lim_ff <= lim_in; best_i_ff <= best_i_in;
      scan_phase_ff <= scan_phase_in; first_ff <= first_in; data_ff <= data_in;
      if (ctl.cmd == DC_LOAD) begin
         mode_ff <= req.mode;
         val_ff <= DATA_WIDTH'(req.value);
         m_ff <= req.index;
         err_ff <= err_any;
         status_ff <= err_status;
      end
      if (ctl.cmd == DC_SCAN && scan_phase_ff && (a_ff == '0 || better)) best_ff <= rd_ff;
      if (rd_en) rd_ff <= mem[rd_addr[AW-1:0]];
      if (ctl.cmd == DC_RDB) hold_ff <= rd_ff;
      if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
      if (ctl.cmd == DC_FINISH) begin
         case (op_type'(mode_ff))
            OP_FINDMIN, OP_FINDMAX, OP_RMMIN, OP_RMMAX:
               pos_ff <= err_ff ? 5'd0 : 5'(best_i_ff);
            default: pos_ff <= 5'd0;
         endcase
      end
   end

   always_comb begin
      rsp.status     = status_ff;
      rsp.data       = (!err_ff && (mode_ff == OP_REMOVE || mode_ff == OP_READ ||
                        mode_ff == OP_RMMIN || mode_ff == OP_RMMAX))
                       ? 32'($signed(data_ff)) : 32'sd0;
      rsp.position   = pos_ff;
      rsp.cursor_now = 5'(cur_ff);
      rsp.size_now   = 5'(size_ff);
   end
endmodule
`default_nettype wire

/* hw/rtl/cal_ctrl.sv */
// sequencer for the cursor array list
`default_nettype none
module cal_ctrl
   import cal_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire logic [3:0] req_mode,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   input  wire sts_type sts,
   output ctl_type      ctl
);
   typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_RDA, S_RDB, S_WR, S_FIN, S_OUT}
      state_type;
   state_type state_ff;
   logic [3:0] mode_ff;
   logic       swap_hi_ff;
   logic       rev;

   assign rev = (mode_ff == OP_REVERSE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      case (state_ff)
         S_IDLE:  ctl.cmd = req_valid ? DC_LOAD : DC_IDLE;
         S_SCAN:  ctl.cmd = DC_SCAN;
         S_RDA:   ctl.cmd = DC_RDA;
         S_RDB:   ctl.cmd = DC_RDB;
         S_WR:    ctl.cmd = DC_WR;
         S_FIN:   ctl.cmd = DC_FINISH;
         default: ctl.cmd = DC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= '0;
         swap_hi_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               mode_ff <= req_mode;
               swap_hi_ff <= 1'b0;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (sts.err) state_ff <= S_FIN;
               else if (mode_ff inside {OP_FINDMIN, OP_FINDMAX, OP_RMMIN, OP_RMMAX})
                  state_ff <= S_SCAN;
               else state_ff <= S_RDA;
            end
            S_SCAN: if (sts.scan_done)
               state_ff <= (mode_ff inside {OP_RMMIN, OP_RMMAX}) ? S_RDA : S_FIN;
            S_RDA: begin
               if (sts.walk_done && !(mode_ff inside {OP_INSERT, OP_APPEND}))
                  state_ff <= S_FIN;
               else state_ff <= rev ? S_RDB : S_WR;
            end
            S_RDB: state_ff <= S_WR;
            // reverse writes twice per pair, first pass goes straight back to write
            S_WR: begin
               if (mode_ff inside {OP_INSERT, OP_APPEND, OP_READ} && sts.walk_done)
                  state_ff <= S_FIN;
               else if (rev) begin
                  state_ff <= swap_hi_ff ? S_RDA : S_WR;
                  swap_hi_ff <= ~swap_hi_ff;
               end
               else state_ff <= S_RDA;
            end
            S_FIN: state_ff <= S_OUT;
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/cursor_array_list_core.sv */
// Cursor array list: fixed-capacity ordered list with a cursor.
// Cursor-only and error operations pass from the input transfer through the check and finish
// states to the result; shifts and reversal step through read and write states for each moved
// element and the min/max search scans each element, so remove min/max on a full list is longest.
// One item at a time: the next input transfer can come in the cycle after the result transfer.
// Reset (synchronous): list size and cursor become zero; memory contents are kept.
`default_nettype none
module cursor_array_list_core
   import cal_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   ctl_type ctl;
   sts_type sts;

   cal_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_mode(req_data.mode),
      .rsp_valid, .rsp_stall, .sts, .ctl
   );

   cal_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock, .reset, .req(req_data), .ctl, .sts, .rsp(rsp_data)
   );
endmodule
`default_nettype wire

/* bench/testbench.sv */
// testbench for the cursor array list: directed and random operation streams against a predictor
`default_nettype none
module testbench
   import cal_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = CAPACITY_DEF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   cursor_array_list_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor copy of the list
   logic signed [31:0] list_mem [CAP];
   int unsigned        list_len;
   int unsigned        cur_pos;
   rsp_type            pending_rsp [$];
   int                 mismatches;
   int                 rsp_count;
   int                 op_seen [16];
   int                 burst_left;
   bit                 stall_mode;

   function automatic void drop_at(int unsigned p);
      for (int unsigned i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
      list_len--;
   endfunction

   function automatic int unsigned extreme_at(bit want_max);
      int unsigned best;
      best = 0;
      for (int unsigned i = 1; i < list_len; i++)
         if (want_max ? (list_mem[best] < list_mem[i]) : (list_mem[i] < list_mem[best]))
            best = i;
      return best;
   endfunction

   function automatic rsp_type apply_list_op(req_type r);
      rsp_type            o;
      op_type             op;
      logic signed [31:0] t;
      int unsigned        m, n;
      o  = '0;
      op = op_type'(r.mode);
      m  = r.index;
      n  = r.last_index;
      o.status = ST_OK;
      case (op)
         OP_CLEAR: begin
            list_len = 0;
            cur_pos  = 0;
         end
         OP_INSERT, OP_APPEND: begin
            if (list_len >= CAP) o.status = ST_FULL;
            else if (op == OP_APPEND) list_mem[list_len++] = r.value;
            else begin
               for (int unsigned i = list_len; i > cur_pos; i--) list_mem[i] = list_mem[i - 1];
               list_mem[cur_pos] = r.value;
               list_len++;
            end
         end
         OP_REMOVE, OP_READ: begin
            if (cur_pos >= list_len) o.status = ST_EMPTY;
            else begin
               o.data = list_mem[cur_pos];
               if (op == OP_REMOVE) drop_at(cur_pos);
            end
         end
         OP_START: cur_pos = 0;
         OP_END:   cur_pos = list_len ? list_len - 1 : 0;
         OP_PREV:  if (cur_pos != 0) cur_pos--;
         OP_NEXT:  if (cur_pos < list_len) cur_pos++;
         OP_SEEK: begin
            if (m > list_len) o.status = ST_RANGE;
            else cur_pos = m;
         end
         OP_REVERSE: begin
            for (int unsigned i = 0; i < list_len / 2; i++) begin
               t = list_mem[i];
               list_mem[i] = list_mem[list_len - 1 - i];
               list_mem[list_len - 1 - i] = t;
            end
            cur_pos = list_len - cur_pos;
         end
         OP_FINDMIN, OP_FINDMAX, OP_RMMIN, OP_RMMAX: begin
            if (list_len == 0) o.status = ST_EMPTY;
            else begin
               o.position = 5'(extreme_at(op == OP_FINDMAX || op == OP_RMMAX));
               if (op == OP_RMMIN || op == OP_RMMAX) begin
                  o.data = list_mem[o.position];
                  drop_at(o.position);
               end
            end
         end
         default: begin
            if (m <= n) begin
               if (n >= list_len) o.status = ST_RANGE;
               else for (int unsigned i = m; i <= n; i++) drop_at(m);
            end
         end
      endcase
      if (cur_pos > list_len) cur_pos = list_len;
      o.cursor_now = 5'(cur_pos);
      o.size_now   = 5'(list_len);
      return o;
   endfunction

   // sender: bursts of random length with random gaps, each transfer held until accepted
   task automatic send_op(op_type op, logic [31:0] val = $urandom(),
                          logic [4:0] m = 5'($urandom()), logic [4:0] n = 5'($urandom()));
      req_type r;
      r.mode = op; r.value = val; r.index = m; r.last_index = n;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(apply_list_op(r));
      op_seen[op]++;
   endtask

   // receiver stall pattern, switches between busy and free stretches
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      rsp_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: %p", rsp_data);
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (e !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", e, rsp_data);
            end
         end
      end
   end

   function automatic logic [31:0] edge_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0;
         4: return 32'($urandom_range(0, 7));
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed();
      send_op(OP_REMOVE);
      send_op(OP_FINDMIN);
      send_op(OP_RMMAX);
      send_op(OP_END);
      send_op(OP_APPEND, 32'h8000_0000);
      send_op(OP_APPEND, 32'h7fff_ffff);
      send_op(OP_INSERT, 32'hffff_ffff);
      send_op(OP_APPEND, 32'h7fff_ffff);
      send_op(OP_FINDMAX);
      send_op(OP_FINDMIN);
      send_op(OP_SEEK, 0, 5'd31);
      send_op(OP_SEEK, 0, 5'd4);
      send_op(OP_READ);
      send_op(OP_PREV);
      send_op(OP_REVERSE);
      send_op(OP_READ);
      send_op(OP_RMRANGE, 0, 5'd3, 5'd1);
      send_op(OP_RMRANGE, 0, 5'd0, 5'd31);
      send_op(OP_RMRANGE, 0, 5'd1, 5'd2);
      send_op(OP_NEXT);
      send_op(OP_NEXT);
      send_op(OP_START);
      send_op(OP_RMMIN);
      send_op(OP_CLEAR);
   endtask

   task automatic test_fill_overflow();
      for (int i = 0; i < CAP + 2; i++) send_op(i[0] ? OP_APPEND : OP_INSERT, edge_value());
      send_op(OP_RMMAX);
      send_op(OP_RMMIN);
      send_op(OP_REVERSE);
      send_op(OP_RMRANGE, 0, 5'd0, 5'd13);
      send_op(OP_CLEAR);
   endtask

   task automatic test_random(int count);
      op_type op;
      int unsigned lim;
      for (int k = 0; k < count; k++) begin
         // growth-heavy when short, otherwise random operations
         if (list_len < 4 && $urandom_range(0, 1))
            op = $urandom_range(0, 1) ? OP_INSERT : OP_APPEND;
         else if ($urandom_range(0, 60) == 0) op = OP_CLEAR;
         else op = op_type'($urandom_range(1, 15));
         lim = list_len + 1;
         if ($urandom_range(0, 4) == 0) send_op(op, edge_value());
         else if (op == OP_RMRANGE && $urandom_range(0, 3) != 0 && list_len > 0) begin
            logic [4:0] a, b;
            a = 5'($urandom_range(0, list_len - 1));
            b = 5'($urandom_range(a, list_len - 1));
            send_op(op, $urandom(), a, b);
         end else
            send_op(op, edge_value(),
                    $urandom_range(0, 2) ? 5'($urandom_range(0, lim)) : 5'($urandom()),
                    $urandom_range(0, 2) ? 5'($urandom_range(0, lim)) : 5'($urandom()));
      end
   endtask

   initial begin
      int wait_cycles;
      int ops_hit;
      mismatches = 0;
      rsp_count  = 0;
      burst_left = 0;
      list_len   = 0;
      cur_pos    = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_overflow();
      test_random(1850);
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (3 * CAP + 20) @(posedge clock);
      ops_hit = 0;
      foreach (op_seen[i]) if (op_seen[i] > 0) ops_hit++;
      $display("covered %0d transfers checked, %0d of 16 operations, full and empty lists",
               rsp_count, ops_hit);
      $display("mismatches %0d, left waiting %0d", mismatches, pending_rsp.size());
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
